/* src/bscl_pkg.sv */
// Shared constants, config register codes and matrix coefficients for the colour limiter.
`timescale 1ns / 1ps

package bscl_pkg;

    localparam int FRACTION_BITS_DEF = 14;
    localparam int PIX_W             = 8;
    localparam int LIM_W             = 15;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STANDARD        = 3'd0,
        REG_TEST_ONLY       = 3'd1,
        REG_FIX_METHOD      = 3'd2,
        REG_FILL_RED        = 3'd3,
        REG_FILL_GREEN      = 3'd4,
        REG_FILL_BLUE       = 3'd5,
        REG_CHROMA_LIMIT    = 3'd6,
        REG_COMPOSITE_LIMIT = 3'd7
    } cfg_reg_t;

    localparam logic [LIM_W-1:0] CHROMA_LIMIT_RST    = 15'd8856;
    localparam logic [LIM_W-1:0] COMPOSITE_LIMIT_RST = 15'd18156;

    // [standard][row][channel] in units of 1e-4; row 0 is luma
    localparam int COEF_E4 [2][3][3] = '{
        '{ '{2989, 5866, 1144}, '{5959, -2741, -3218}, '{2113, -5227, 3113} },
        '{ '{2989, 5866, 1144}, '{-1473, -2891, 4364}, '{6149, -5145, -1004} }
    };

    // round half up of coef * 2^frac / 10000
    function automatic longint coef_q(int std_sel, int row, int col, int frac);
        longint n;
        n = longint'(COEF_E4[std_sel][row][col]) * (longint'(1) << frac) * 2 + 10000;
        if (n >= 0) begin
            return n / 20000;
        end else begin
            return -((-n + 19999) / 20000);
        end
    endfunction

endpackage

/* src/bscl_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module bscl_sqrt #(
    parameter int RW = 15
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [2*RW-1:0] v_in,
    output logic [RW-1:0]   root_out
);
    localparam int VW  = 2 * RW;
    localparam int RMW = RW + 3;

    logic [VW-1:0]  v_reg    [RW+1];
    logic [RMW-1:0] rem_reg  [RW+1];
    logic [RW-1:0]  root_reg [RW+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg[0]    <= v_in;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < RW; i++) begin : g_stage
        logic [RMW-1:0] rem_next;
        logic [RMW-1:0] trial;
        always_comb begin
            rem_next = {rem_reg[i][RMW-3:0], v_reg[i][VW-1:VW-2]};
            trial    = RMW'({root_reg[i], 2'b01});
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[i+1] <= {v_reg[i][VW-3:0], 2'b00};
                if (rem_next >= trial) begin
                    rem_reg[i+1]  <= rem_next - trial;
                    root_reg[i+1] <= {root_reg[i][RW-2:0], 1'b1};
                end else begin
                    rem_reg[i+1]  <= rem_next;
                    root_reg[i+1] <= {root_reg[i][RW-2:0], 1'b0};
                end
            end
        end
    end

    assign root_out = root_reg[RW];

endmodule

/* src/bscl_div.sv */
// Pipelined restoring divider: floor(a * 2^F / d), saturating above 2^(F+1)-1.
`timescale 1ns / 1ps

module bscl_div #(
    parameter int F  = 14,
    parameter int AW = 15,
    parameter int DW = 16
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [AW-1:0] a_in,
    input  logic [DW-1:0] d_in,
    output logic [F:0]    q_out
);
    localparam int NS = F + 1;
    localparam int SW = (AW > DW + 1) ? AW + 1 : DW + 2;

    logic [DW:0]   r_reg   [NS+1];
    logic [DW-1:0] d_reg   [NS+1];
    logic [F:0]    q_reg   [NS+1];
    logic          sat_reg [NS+1];
    logic          abit_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            // quotient overflows F+1 bits exactly when a >= 2d
            sat_reg[0] <= SW'(a_in) >= SW'({d_in, 1'b0});
            r_reg[0]   <= (DW+1)'(a_in >> 1);
            abit_reg   <= a_in[0];
            d_reg[0]   <= d_in;
            q_reg[0]   <= '0;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        logic [DW:0] r_next;
        always_comb begin
            r_next = {r_reg[i][DW-1:0], (i == 0) ? abit_reg : 1'b0};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[i+1]   <= d_reg[i];
                sat_reg[i+1] <= sat_reg[i];
                if (r_next >= (DW+1)'(d_reg[i])) begin
                    r_reg[i+1] <= r_next - (DW+1)'(d_reg[i]);
                    q_reg[i+1] <= {q_reg[i][F-1:0], 1'b1};
                end else begin
                    r_reg[i+1] <= r_next;
                    q_reg[i+1] <= {q_reg[i][F-1:0], 1'b0};
                end
            end
        end
    end

    assign q_out = sat_reg[NS] ? '1 : q_reg[NS];

endmodule

/* src/broadcast_safe_color_limiter.sv */
// Top level of the broadcast-safe colour limiter pipeline.
`timescale 1ns / 1ps

// Broadcast-safe colour limiter. Each RGBA beat is converted to Y and two chroma
// components (NTSC YIQ or PAL YUV), tested against the chroma and composite limits
// and, when it fails, either painted with the fill colour or repaired by scaling
// luminance or saturation. One pixel is accepted every clock. The pipe has six front
// stages for the input capture, the matrix, the divide by 255, the squares and the
// limit test, FRACTION_BITS+2 stages of square root, FRACTION_BITS+2 stages of the
// two parallel scale dividers and three back stages for the scale select, the
// products and the rounding. The whole pipe advances together; holding m_tready low
// while a result waits freezes it, and s_tready drops with it.
// Configuration is taken on any cycle (cfg_ready is always high) but must only be
// changed while no pixel is in flight.
module broadcast_safe_color_limiter #(
    parameter int FRACTION_BITS = bscl_pkg::FRACTION_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [31:0]                           s_tdata,   // red, green, blue, alpha
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [31:0]                           m_tdata,   // red_out, green_out, blue_out, alpha_out
    output logic                                  m_tuser,   // failed
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bscl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bscl_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import bscl_pkg::*;

    localparam int F      = FRACTION_BITS;
    localparam int CQW    = F + 2;            // coefficient
    localparam int AW     = F + 10;           // matrix accumulator
    localparam int MW     = F + 11;           // offset dividend for /510
    localparam int RCW    = F + 12;           // reciprocal of 510
    localparam int PW     = MW + RCW;
    localparam int SH     = F + 20;
    localparam int CW     = F + 2;            // Y / chroma component
    localparam int KW     = ((LIM_W + 1 > CW) ? LIM_W + 1 : CW) + 1;
    localparam int SQW    = 2 * KW;
    localparam int RW     = F + 1;            // chroma magnitude
    localparam int VW     = 2 * RW;
    localparam int DW     = F + 2;            // divisor
    localparam int LS     = RW + 1;           // sqrt latency
    localparam int LD     = F + 2;            // divider latency
    localparam int LPW    = F + 9;
    localparam int DSW    = F + 10;
    localparam int SPW    = 2 * F + 12;
    localparam int NW     = 2 * F + 12;

    localparam longint OFFSET = 510 * (longint'(1) << (F + 1));
    localparam longint RECIP  = (longint'(1) << SH) / 510 + 1;
    localparam logic [RCW-1:0] RECIP_Q = RCW'(RECIP);
    localparam logic signed [F+3:0] KOFF = (F+4)'(longint'(1) << (F + 1));
    localparam logic [F:0] ONE = (F+1)'(longint'(1) << F);

    typedef struct packed {
        logic [PIX_W-1:0]       r;
        logic [PIX_W-1:0]       g;
        logic [PIX_W-1:0]       b;
        logic [PIX_W-1:0]       a;
        logic                   pass;
        logic signed [CW-1:0]   y;
        logic signed [KW-1:0]   kmy;
        logic                   use_t;
        logic                   tneg;
    } sb_t;

    // ---------------- configuration registers ----------------
    logic              standard_reg, test_only_reg, fix_method_reg;
    logic [PIX_W-1:0]  fill_red_reg, fill_green_reg, fill_blue_reg;
    logic [LIM_W-1:0]  chroma_limit_reg, composite_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            standard_reg        <= 1'b0;
            test_only_reg       <= 1'b0;
            fix_method_reg      <= 1'b1;
            fill_red_reg        <= '0;
            fill_green_reg      <= '0;
            fill_blue_reg       <= '0;
            chroma_limit_reg    <= CHROMA_LIMIT_RST;
            composite_limit_reg <= COMPOSITE_LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_STANDARD:        standard_reg        <= cfg_data[0];
                REG_TEST_ONLY:       test_only_reg       <= cfg_data[0];
                REG_FIX_METHOD:      fix_method_reg      <= cfg_data[0];
                REG_FILL_RED:        fill_red_reg        <= cfg_data[PIX_W-1:0];
                REG_FILL_GREEN:      fill_green_reg      <= cfg_data[PIX_W-1:0];
                REG_FILL_BLUE:       fill_blue_reg       <= cfg_data[PIX_W-1:0];
                REG_CHROMA_LIMIT:    chroma_limit_reg    <= cfg_data[LIM_W-1:0];
                REG_COMPOSITE_LIMIT: composite_limit_reg <= cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipe control ----------------
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Matrix coefficients, both standards fixed at elaboration
    logic signed [CQW-1:0] cq [3][3];
    for (genvar k = 0; k < 3; k++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            localparam longint C_NTSC = coef_q(0, k, j, F);
            localparam longint C_PAL  = coef_q(1, k, j, F);
            assign cq[k][j] = standard_reg ? CQW'(C_PAL) : CQW'(C_NTSC);
        end
    end

    // ---------------- stage 1: input capture ----------------
    logic v1_reg;
    sb_t  sb1_reg, sb1_next;

    always_comb begin
        sb1_next      = '0;
        sb1_next.r    = s_tdata[7:0];
        sb1_next.g    = s_tdata[15:8];
        sb1_next.b    = s_tdata[23:16];
        sb1_next.a    = s_tdata[31:24];
        sb1_next.pass = s_tdata[31:24] < 8'd3;   // low alpha passes untouched
    end

    // ---------------- stage 2: matrix ----------------
    logic                 v2_reg;
    sb_t                  sb2_reg;
    logic signed [AW-1:0] acc_reg  [3];
    logic signed [AW-1:0] acc_next [3];
    logic [PIX_W-1:0]     px1 [3];

    assign px1[0] = sb1_reg.r;
    assign px1[1] = sb1_reg.g;
    assign px1[2] = sb1_reg.b;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            acc_next[k] = '0;
            for (int j = 0; j < 3; j++) begin
                acc_next[k] = acc_next[k]
                            + AW'(cq[k][j]) * AW'($signed({1'b0, px1[j]}));
            end
        end
    end

    // ---------------- stage 3: reciprocal product for /510 ----------------
    logic            v3_reg;
    sb_t             sb3_reg;
    logic [PW-1:0]   prod_reg  [3];
    logic [PW-1:0]   prod_next [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [MW:0] mt;
            // round half up of acc/255 is floor((2acc+255)/510); offset keeps it positive
            mt = ((MW+1)'(acc_reg[k]) <<< 1) + (MW+1)'(255) + (MW+1)'(OFFSET);
            prod_next[k] = PW'(mt[MW-1:0]) * PW'(RECIP_Q);
        end
    end

    // ---------------- stage 4: components ----------------
    logic                 v4_reg;
    sb_t                  sb4_reg;
    logic signed [CW-1:0] comp_reg  [3];
    logic signed [CW-1:0] comp_next [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [F+3:0] ct;
            ct = $signed({1'b0, prod_reg[k][PW-1:SH]}) - KOFF;
            comp_next[k] = CW'(ct);
        end
    end

    // ---------------- stage 5: squares ----------------
    logic                   v5_reg;
    sb_t                    sb5_reg, sb5_next;
    logic signed [2*CW-1:0] c1sq_reg, c2sq_reg;
    logic signed [SQW-1:0]  kmysq_reg;
    logic [2*LIM_W-1:0]     limcsq_reg;

    always_comb begin
        sb5_next     = sb4_reg;
        sb5_next.y   = comp_reg[0];
        sb5_next.kmy = $signed(KW'(composite_limit_reg)) - KW'(comp_reg[0]);
    end

    // ---------------- stage 6: limit test ----------------
    logic           v6_reg;
    sb_t            sb6_reg, sb6_next;
    logic [VW-1:0]  c2_reg;
    logic signed [2*CW-1:0] c2_sum;

    always_comb begin
        c2_sum        = c1sq_reg + c2sq_reg;
        sb6_next      = sb5_reg;
        sb6_next.pass = sb5_reg.pass
                     || ((SQW'(c2_sum) <= SQW'(limcsq_reg))
                      && (SQW'(c2_sum) <= SQW'(kmysq_reg)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb1_reg    <= sb1_next;
            sb2_reg    <= sb1_reg;
            acc_reg    <= acc_next;
            sb3_reg    <= sb2_reg;
            prod_reg   <= prod_next;
            sb4_reg    <= sb3_reg;
            comp_reg   <= comp_next;
            sb5_reg    <= sb5_next;
            c1sq_reg   <= (2*CW)'(comp_reg[1]) * (2*CW)'(comp_reg[1]);
            c2sq_reg   <= (2*CW)'(comp_reg[2]) * (2*CW)'(comp_reg[2]);
            kmysq_reg  <= SQW'(sb5_next.kmy) * SQW'(sb5_next.kmy);
            limcsq_reg <= (2*LIM_W)'(chroma_limit_reg) * (2*LIM_W)'(chroma_limit_reg);
            sb6_reg    <= sb6_next;
            c2_reg     <= VW'(c2_sum);
        end
    end

    // ---------------- chroma magnitude ----------------
    logic [RW-1:0] chroma;
    logic [LS-1:0] va_reg;
    sb_t           sba_reg [LS];

    bscl_sqrt #(.RW(RW)) u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .v_in     (c2_reg),
        .root_out (chroma)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= '0;
        end else if (en) begin
            va_reg <= {va_reg[LS-2:0], v6_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sba_reg[0] <= sb6_reg;
            for (int i = 1; i < LS; i++) begin
                sba_reg[i] <= sba_reg[i-1];
            end
        end
    end

    // ---------------- scale dividers ----------------
    sb_t                   sbb_next;
    sb_t                   sbb_reg [LD];
    logic [LD-1:0]         vb_reg;
    logic [RW-1:0]         chroma1;
    logic signed [F+2:0]   den;
    logic [LIM_W-1:0]      a2;
    logic [DW-1:0]         d2;
    logic [F:0]            q1, q2;

    always_comb begin
        sb_t sa;
        sa       = sba_reg[LS-1];
        chroma1  = (chroma == '0) ? RW'(1) : chroma;
        den      = (F+3)'(sa.y) + $signed((F+3)'(chroma1));
        sbb_next = sa;
        if (fix_method_reg) begin
            // saturation: (composite - Y) / chroma, negative means full desaturation
            sbb_next.use_t = 1'b1;
            sbb_next.tneg  = sa.kmy < 0;
            a2 = LIM_W'(sa.kmy);
            d2 = DW'(chroma1);
        end else begin
            // luminance: composite / (Y + chroma), only when the divisor is positive
            sbb_next.use_t = den > 0;
            sbb_next.tneg  = 1'b0;
            a2 = composite_limit_reg;
            d2 = (den > 0) ? DW'(den) : DW'(1);
        end
    end

    bscl_div #(.F(F), .AW(LIM_W), .DW(DW)) u_div_chroma (
        .aclk  (aclk),
        .en    (en),
        .a_in  (chroma_limit_reg),
        .d_in  (DW'(chroma1)),
        .q_out (q1)
    );

    bscl_div #(.F(F), .AW(LIM_W), .DW(DW)) u_div_comp (
        .aclk  (aclk),
        .en    (en),
        .a_in  (a2),
        .d_in  (d2),
        .q_out (q2)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= '0;
        end else if (en) begin
            vb_reg <= {vb_reg[LD-2:0], va_reg[LS-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sbb_reg[0] <= sbb_next;
            for (int i = 1; i < LD; i++) begin
                sbb_reg[i] <= sbb_reg[i-1];
            end
        end
    end

    // ---------------- scale select ----------------
    logic       vs_reg;
    sb_t        sbs_reg;
    logic [F:0] s_reg, s_next;

    always_comb begin
        sb_t sq;
        sq     = sbb_reg[LD-1];
        s_next = q1;
        if (sq.use_t) begin
            if (sq.tneg) begin
                s_next = '0;
            end else if (q2 < s_next) begin
                s_next = q2;
            end
        end
        if (s_next > ONE) begin
            s_next = ONE;
        end
    end

    // ---------------- products ----------------
    logic                  vm_reg;
    sb_t                   sbm_reg;
    logic [LPW-1:0]        lp_reg [3];
    logic signed [SPW-1:0] sp_reg [3];
    logic [LPW-1:0]        lp_next [3];
    logic signed [SPW-1:0] sp_next [3];
    logic [PIX_W-1:0]      pxs [3];

    assign pxs[0] = sbs_reg.r;
    assign pxs[1] = sbs_reg.g;
    assign pxs[2] = sbs_reg.b;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            logic signed [DSW-1:0] dsat;
            dsat = $signed(DSW'({pxs[j], F'(0)})) - DSW'(sbs_reg.y) * DSW'(255);
            lp_next[j] = LPW'(s_reg) * LPW'(pxs[j]);
            sp_next[j] = $signed(SPW'(s_reg)) * SPW'(dsat);
        end
    end

    // ---------------- rounding, clamp and output ----------------
    logic [PIX_W-1:0] ch_next [3];
    logic [PIX_W-1:0] ch_reg  [3];
    logic [PIX_W-1:0] alpha_reg;
    logic             failed_reg;
    logic [PIX_W-1:0] pxm [3];
    logic [PIX_W-1:0] fill [3];

    assign pxm[0]  = sbm_reg.r;
    assign pxm[1]  = sbm_reg.g;
    assign pxm[2]  = sbm_reg.b;
    assign fill[0] = fill_red_reg;
    assign fill[1] = fill_green_reg;
    assign fill[2] = fill_blue_reg;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            logic [LPW-1:0]       lr;
            logic signed [NW-1:0] num;
            logic signed [11:0]   sr;
            lr  = lp_reg[j] + LPW'(longint'(1) << (F - 1));
            num = ((NW'(sbm_reg.y) * NW'(255)) <<< F) + NW'(sp_reg[j])
                + NW'(longint'(1) << (2 * F - 1));
            sr  = num[NW-1:2*F];
            if (sbm_reg.pass) begin
                ch_next[j] = pxm[j];
            end else if (test_only_reg) begin
                ch_next[j] = fill[j];
            end else if (!fix_method_reg) begin
                ch_next[j] = (lr[LPW-1:F] > 9'd255) ? 8'd255 : lr[F+7:F];
            end else if (sr < 0) begin
                ch_next[j] = 8'd0;
            end else if (sr > 12'sd255) begin
                ch_next[j] = 8'd255;
            end else begin
                ch_next[j] = sr[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vs_reg        <= 1'b0;
            vm_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vs_reg        <= vb_reg[LD-1];
            vm_reg        <= vs_reg;
            out_valid_reg <= vm_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sbs_reg    <= sbb_reg[LD-1];
            s_reg      <= s_next;
            sbm_reg    <= sbs_reg;
            lp_reg     <= lp_next;
            sp_reg     <= sp_next;
            ch_reg     <= ch_next;
            alpha_reg  <= sbm_reg.a;
            failed_reg <= !sbm_reg.pass;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {alpha_reg, ch_reg[2], ch_reg[1], ch_reg[0]};
    assign m_tuser  = failed_reg;

endmodule
